@@ sv/ppcd_pkg.sv @@
// Shared types and constants for the packed pattern cell decoder.
`default_nettype none
package ppcd_pkg;

  // Lead byte flag: set means presence mask, clear means the byte is a note
  localparam int unsigned LEAD_MASK_BIT = 7;

  // Note decode constants
  localparam logic [7:0] NOTE_OFF_MIN  = 8'd96;
  localparam logic [6:0] NOTE_OFF_CODE = 7'd100;
  localparam logic [6:0] SEMITONES     = 7'd12;
  localparam logic [6:0] NAME_WRAP     = 7'd12;

  // Field count per cell and mask bit positions
  localparam int unsigned NUM_FIELDS = 5;
  localparam int unsigned F_NOTE = 0;
  localparam int unsigned F_INST = 1;
  localparam int unsigned F_VOL  = 2;
  localparam int unsigned F_EFF  = 3;
  localparam int unsigned F_EVAL = 4;

  // Output beat layout
  localparam int unsigned TDATA_W = 64;

  // Parser state: lead byte or one of the five field bytes
  typedef enum logic [5:0] {
    ST_LEAD = 6'b000001,
    ST_NOTE = 6'b000010,
    ST_INST = 6'b000100,
    ST_VOL  = 6'b001000,
    ST_EFF  = 6'b010000,
    ST_EVAL = 6'b100000
  } state_t;

  // One decoded cell
  typedef struct packed {
    logic [6:0]        channel;
    logic [7:0]        effect_value;
    logic [7:0]        effect;
    logic [7:0]        volume;
    logic signed [8:0] instrument;
    logic [7:0]        octave;
    logic [6:0]        note_name;
    logic [4:0]        present_mask;
  } cell_t;

endpackage
`default_nettype wire

@@ sv/ppcd_note_dec.sv @@
// Splits a raw note byte into semitone name and octave.
`default_nettype none
module ppcd_note_dec (
  input  wire logic [7:0] note_byte,
  output logic      [6:0] note_name,
  output logic      [7:0] octave
);

  logic [8:0] quot_prod;
  logic [2:0] quot;
  logic [6:0] rem;
  logic [6:0] quot_x12;

  // note / 12 = (note / 4) / 3; x / 3 == (x * 11) >> 5 for x below 24
  always_comb begin
    quot_prod = {4'd0, note_byte[6:2]} * 9'd11;
    quot      = quot_prod[7:5];
    quot_x12  = {4'd0, quot} * ppcd_pkg::SEMITONES;
    rem       = note_byte[6:0] - quot_x12;
  end

  // Note off above the range; a zero remainder wraps to name 12, octave down
  always_comb begin
    if (note_byte >= ppcd_pkg::NOTE_OFF_MIN) begin
      note_name = ppcd_pkg::NOTE_OFF_CODE;
      octave    = 8'd0;
    end else if (rem == 7'd0) begin
      note_name = ppcd_pkg::NAME_WRAP;
      octave    = {5'd0, quot} - 8'd1;
    end else begin
      note_name = rem;
      octave    = {5'd0, quot};
    end
  end

endmodule
`default_nettype wire

@@ sv/packed_pattern_cell_decoder.sv @@
// Top level: byte-stream parser and output register of the pattern cell decoder.
//
// Usage:
//   in_*  : one raw pattern byte per beat (in_tdata[7:0]).
//   out_* : one decoded cell per beat; out_tlast marks the last channel of a row.
//   cfg_* : cfg_we writes the channel count per row (cfg_wdata); 0 acts as 1.
// A cell is a lead byte (mask with bit 7 set, or a note with bit 7 clear)
// followed by the bytes its mask announces. The cell leaves on the beat after
// its last byte is taken. Throughput is one byte per cycle while in_tready is
// high; the parser state and the output register are the only pipeline, so
// bytes that finish a cell can follow back to back. When the receiver stalls,
// the held cell stays on out_*, and in_tready drops only while a cell waits
// and out_tready is low.
// Reset (rst_n low, synchronous) returns the parser to the lead byte, clears
// the channel counter, empties the output register and sets channel count 1.
`default_nettype none
module packed_pattern_cell_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [ppcd_pkg::TDATA_W-1:0] out_tdata,  // [4:0] present_mask, [11:5] note_name,
                                       // [19:12] octave, [28:20] instrument,
                                       // [36:29] volume, [44:37] effect,
                                       // [52:45] effect_value, [59:53] channel
  output logic             out_tlast,  // row_end
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);

  ppcd_pkg::state_t state_r, state_nxt;
  logic [4:0] mask_r, mask_nxt;
  logic [7:0] note_r, note_nxt;
  logic [7:0] inst_r, inst_nxt;
  logic [7:0] vol_r, vol_nxt;
  logic [7:0] eff_r, eff_nxt;
  logic [7:0] eval_nxt;
  logic [6:0] ch_r, ch_nxt;
  logic [6:0] count_r;
  logic [4:0] above;
  logic [4:0] rem;
  logic [4:0] low_bit;
  logic       emit;
  logic       in_fire;
  logic       last;
  logic [7:0] ch_plus;
  logic [6:0] dec_name;
  logic [7:0] dec_oct;
  ppcd_pkg::cell_t cell_nxt, cell_r;
  logic       last_r;
  logic       out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Capture this byte into its field; 'above' marks fields still to come
  always_comb begin
    mask_nxt = mask_r;
    note_nxt = note_r;
    inst_nxt = inst_r;
    vol_nxt  = vol_r;
    eff_nxt  = eff_r;
    eval_nxt = 8'd0;
    above    = 5'b00000;
    unique case (state_r)
      ppcd_pkg::ST_LEAD: begin
        note_nxt = 8'd0;
        inst_nxt = 8'd0;
        vol_nxt  = 8'd0;
        eff_nxt  = 8'd0;
        if (in_tdata[ppcd_pkg::LEAD_MASK_BIT]) begin
          mask_nxt = in_tdata[4:0];
          above    = 5'b11111;
        end else begin
          mask_nxt = 5'b11111;
          note_nxt = in_tdata;
          above    = 5'b11110;
        end
      end
      ppcd_pkg::ST_NOTE: begin
        note_nxt = in_tdata;
        above    = 5'b11110;
      end
      ppcd_pkg::ST_INST: begin
        inst_nxt = in_tdata;
        above    = 5'b11100;
      end
      ppcd_pkg::ST_VOL: begin
        vol_nxt = in_tdata;
        above   = 5'b11000;
      end
      ppcd_pkg::ST_EFF: begin
        eff_nxt = in_tdata;
        above   = 5'b10000;
      end
      ppcd_pkg::ST_EVAL: begin
        eval_nxt = in_tdata;
        above    = 5'b00000;
      end
      default: begin
        above = 5'b00000;
      end
    endcase
  end

  // Next field to read is the lowest remaining mask bit; none left emits
  always_comb begin
    rem     = mask_nxt & above;
    low_bit = rem & (~rem + 5'd1);
    emit    = (rem == 5'd0);
    if (emit) begin
      state_nxt = ppcd_pkg::ST_LEAD;
    end else begin
      state_nxt = ppcd_pkg::state_t'({low_bit, 1'b0});
    end
  end

  ppcd_note_dec u_note_dec (
    .note_byte (note_nxt),
    .note_name (dec_name),
    .octave    (dec_oct)
  );

  // Row position
  always_comb begin
    ch_plus = {1'b0, ch_r} + 8'd1;
    last    = (ch_plus >= {1'b0, count_r});
    ch_nxt  = last ? 7'd0 : ch_plus[6:0];
  end

  // Assemble the cell, absent fields read as zero
  always_comb begin
    cell_nxt.present_mask = mask_nxt;
    cell_nxt.note_name    = mask_nxt[ppcd_pkg::F_NOTE] ? dec_name : 7'd0;
    cell_nxt.octave       = mask_nxt[ppcd_pkg::F_NOTE] ? dec_oct : 8'd0;
    cell_nxt.instrument   = mask_nxt[ppcd_pkg::F_INST] ?
                            ($signed({1'b0, inst_nxt}) - 9'sd1) : 9'sd0;
    cell_nxt.volume       = mask_nxt[ppcd_pkg::F_VOL]  ? vol_nxt  : 8'd0;
    cell_nxt.effect       = mask_nxt[ppcd_pkg::F_EFF]  ? eff_nxt  : 8'd0;
    cell_nxt.effect_value = mask_nxt[ppcd_pkg::F_EVAL] ? eval_nxt : 8'd0;
    cell_nxt.channel      = ch_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppcd_pkg::ST_LEAD;
      mask_r      <= 5'd0;
      ch_r        <= 7'd0;
      count_r     <= 7'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (in_fire) begin
        state_r <= state_nxt;
        mask_r  <= mask_nxt;
        if (emit) begin
          ch_r <= ch_nxt;
        end
      end
      if (in_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Field bytes and output register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      note_r <= note_nxt;
      inst_r <= inst_nxt;
      vol_r  <= vol_nxt;
      eff_r  <= eff_nxt;
      if (emit) begin
        cell_r <= cell_nxt;
        last_r <= last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, cell_r};
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

@@ sv/ppcd_checker.sv @@
// Port-level checks for the pattern cell decoder, bound to the top level.
`default_nettype none
module ppcd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tlast
);

  // A stalled cell holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("held cell changed");

  // Input is only blocked by a waiting cell
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // Absent note gives zero name and octave
  a_no_note: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[19:5] == 15'd0)
    else $error("absent note not zero");

  // Note off carries octave zero
  a_note_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:5] == 7'd100 |-> out_tdata[19:12] == 8'd0)
    else $error("note off with octave");

  // A cell only appears after a byte beat
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid ##1 out_tvalid |-> $past(in_tvalid && in_tready))
    else $error("cell without input byte");

endmodule

bind packed_pattern_cell_decoder ppcd_checker u_ppcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

@@ sim/tb_packed_pattern_cell_decoder.sv @@
// Self-checking testbench for the packed pattern cell decoder byte stream.
`timescale 1ns / 1ps

module tb_packed_pattern_cell_decoder;

  localparam int unsigned HOLD_CYCLES = 200;

  // One expected output beat: the cell plus its row-end flag
  typedef struct {
    ppcd_pkg::cell_t decoded;
    logic            row_end;
  } cell_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;          // [4:0] present_mask, [11:5] note_name, [19:12] octave,
                                   // [28:20] instrument, [36:29] volume, [44:37] effect,
                                   // [52:45] effect_value, [59:53] channel
  logic        out_tlast;          // row_end
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = 7'd0;

  // Decoder shadow state
  ppcd_pkg::state_t parse_st = ppcd_pkg::ST_LEAD;
  logic [4:0]  mask_q = '0;
  logic [7:0]  note_q = '0;
  logic [7:0]  inst_q = '0;
  logic [7:0]  vol_q = '0;
  logic [7:0]  eff_q = '0;
  logic [6:0]  chan_q = '0;
  logic [6:0]  chan_count_q = 7'd1;

  cell_beat_t  cells_due[$];

  // Traffic shaping and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_ticket = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned cells_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;

  packed_pattern_cell_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Build the decoded cell from the shadow state and advance the channel counter
  function automatic void emit_cell(input logic [7:0] eval_byte);
    cell_beat_t beat;
    int         note;
    int         oct;
    beat.decoded = '0;
    beat.decoded.present_mask = mask_q;
    if (mask_q[ppcd_pkg::F_NOTE]) begin
      if (note_q >= ppcd_pkg::NOTE_OFF_MIN) begin
        beat.decoded.note_name = ppcd_pkg::NOTE_OFF_CODE;
      end else begin
        note = note_q % int'(ppcd_pkg::SEMITONES);
        oct  = note_q / int'(ppcd_pkg::SEMITONES);
        if (note == 0) begin
          note = ppcd_pkg::NAME_WRAP;
          oct  = (oct - 1) & 8'hFF;
        end
        beat.decoded.note_name = 7'(note);
        beat.decoded.octave    = 8'(oct);
      end
    end
    if (mask_q[ppcd_pkg::F_INST]) beat.decoded.instrument = {1'b0, inst_q} - 9'd1;
    if (mask_q[ppcd_pkg::F_VOL])  beat.decoded.volume = vol_q;
    if (mask_q[ppcd_pkg::F_EFF])  beat.decoded.effect = eff_q;
    if (mask_q[ppcd_pkg::F_EVAL]) beat.decoded.effect_value = eval_byte;
    beat.decoded.channel = chan_q;
    // count 0 acts as 1; a counter past the count ends the row too
    beat.row_end = (int'(chan_q) + 1 >= int'(chan_count_q));
    chan_q = beat.row_end ? 7'd0 : chan_q + 7'd1;
    cells_due = {cells_due, beat};
  endfunction

  // Advance the parser shadow by one accepted byte
  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0]  eval_byte;
    int unsigned next_field;
    eval_byte = 8'h00;
    if (parse_st == ppcd_pkg::ST_LEAD) begin
      note_q = '0;
      inst_q = '0;
      vol_q  = '0;
      eff_q  = '0;
      if (b[ppcd_pkg::LEAD_MASK_BIT]) begin
        mask_q = b[4:0];
        next_field = ppcd_pkg::F_NOTE;
      end else begin
        mask_q = '1;
        note_q = b;
        next_field = ppcd_pkg::F_INST;
      end
    end else begin
      unique case (parse_st)
        ppcd_pkg::ST_NOTE: begin
          note_q = b;
          next_field = ppcd_pkg::F_INST;
        end
        ppcd_pkg::ST_INST: begin
          inst_q = b;
          next_field = ppcd_pkg::F_VOL;
        end
        ppcd_pkg::ST_VOL: begin
          vol_q = b;
          next_field = ppcd_pkg::F_EFF;
        end
        ppcd_pkg::ST_EFF: begin
          eff_q = b;
          next_field = ppcd_pkg::F_EVAL;
        end
        default: begin
          eval_byte = b;
          next_field = ppcd_pkg::NUM_FIELDS;
        end
      endcase
    end
    // Park on the next announced field, or finish the cell
    for (int unsigned f = next_field; f < ppcd_pkg::NUM_FIELDS; f++) begin
      if (mask_q[f]) begin
        parse_st = ppcd_pkg::state_t'(6'b1 << (f + 1));
        return;
      end
    end
    parse_st = ppcd_pkg::ST_LEAD;
    emit_cell(eval_byte);
  endfunction

  // Send one byte, with an optional idle gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Stop sending and wait for every expected cell, then for the output latency
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_channel_count(input logic [6:0] count);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    chan_count_q = count;
    cfg_writes++;
  endtask

  function automatic logic [7:0] field_byte();
    unique case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] note_pick();
    unique case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd12;
      2:       return 8'd95;
      3:       return 8'd96;
      default: return 8'($urandom);
    endcase
  endfunction

  // Well-formed cell: note lead with all fields, or mask lead with its fields
  task automatic send_random_cell();
    logic [4:0] mask;
    if ($urandom_range(3) == 0) begin
      send_byte(8'($urandom_range(127)));
      for (int unsigned f = ppcd_pkg::F_INST; f < ppcd_pkg::NUM_FIELDS; f++)
        send_byte(field_byte());
    end else begin
      mask = 5'($urandom);
      send_byte({1'b1, 2'($urandom), mask});
      for (int unsigned f = 0; f < ppcd_pkg::NUM_FIELDS; f++) begin
        if (mask[f]) send_byte(f == ppcd_pkg::F_NOTE ? note_pick() : field_byte());
      end
    end
  endtask

  // Field extremes, note wrap and note off, empty mask, ignored mask bits
  task automatic test_directed();
    logic [7:0] seq [] = '{
      8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF,          // note lead 0, instrument 0
      8'h80,                                      // empty cell
      8'hFF, 8'h60, 8'hFF, 8'h00, 8'hFF, 8'h00,   // bits 5, 6 set; note off at 96
      8'h81, 8'd95,                               // note only, top real note
      8'h90, 8'hAA,                               // effect value only
      8'h7F, 8'h55, 8'h01, 8'h80, 8'h7F,          // note lead 127
      8'hE2, 8'h01                                // instrument only
    };
    foreach (seq[i]) send_byte(seq[i]);
    wait_drained();
  endtask

  // Row wrap at the extremes, count zero, count lowered mid-row
  task automatic test_channel_count();
    write_channel_count(7'd127);
    repeat (130) send_byte(8'h80);
    wait_drained();
    write_channel_count(7'd0);
    repeat (3) send_random_cell();
    wait_drained();
    write_channel_count(7'd1);
    repeat (3) send_random_cell();
    wait_drained();
    write_channel_count(7'd8);
    repeat (5) send_random_cell();
    wait_drained();
    write_channel_count(7'd3);
    repeat (4) send_random_cell();
    wait_drained();
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall,
                                  input logic [6:0] count, input int unsigned n);
    int unsigned first;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    write_channel_count(count);
    first = bytes_sent;
    while (bytes_sent - first < n) begin
      // mostly whole cells, some stray bytes that knock the framing off
      if ($urandom_range(99) < 12) send_byte(8'($urandom));
      else send_random_cell();
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    run_random_phase(0, 0, 7'd4, 250);
    run_random_phase(68, 0, 7'd127, 250);
    run_random_phase(0, 68, 7'($urandom_range(2, 12)), 250);
    run_random_phase(9, 9, 7'd1, 250);
  endtask

  // Long receiver hold-off while the sender keeps offering bytes
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_channel_count(7'd3);
    hold_ticket <= hold_ticket + 1;
    repeat (12) send_random_cell();
    wait_drained();
  endtask

  // Receiver: random stalls, or a counted hold-off on request
  always @(posedge clk) begin
    if (hold_ticket != hold_taken) begin
      hold_taken <= hold_ticket;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_cell();
    cell_beat_t      want;
    ppcd_pkg::cell_t got;
    got = ppcd_pkg::cell_t'(out_tdata[59:0]);
    if (cells_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected cell: tdata=%h tlast=%b", $realtime, out_tdata, out_tlast);
      return;
    end
    want = cells_due.pop_front();
    cells_checked++;
    if (got.present_mask !== want.decoded.present_mask ||
        got.note_name !== want.decoded.note_name ||
        got.octave !== want.decoded.octave || got.instrument !== want.decoded.instrument ||
        got.volume !== want.decoded.volume || got.effect !== want.decoded.effect ||
        got.effect_value !== want.decoded.effect_value ||
        got.channel !== want.decoded.channel ||
        out_tdata[63:60] !== 4'h0 || out_tlast !== want.row_end) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] cell mismatch (mask name oct ins vol eff val ch last)", $realtime);
        $display("  exp %h %0d %0d %0d %h %h %h %0d %b", want.decoded.present_mask,
                 want.decoded.note_name, want.decoded.octave, want.decoded.instrument,
                 want.decoded.volume, want.decoded.effect, want.decoded.effect_value,
                 want.decoded.channel, want.row_end);
        $display("  got %h %0d %0d %0d %h %h %h %0d %b pad=%h", got.present_mask,
                 got.note_name, got.octave, got.instrument, got.volume, got.effect,
                 got.effect_value, got.channel, out_tlast, out_tdata[63:60]);
      end
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_cell();
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_channel_count();
    test_random_phases();
    test_backpressure();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d pattern bytes, checked %0d cells over %0d channel-count settings,",
             bytes_sent, cells_checked, cfg_writes);
    $display("with sender gaps, receiver stalls and a %0d-cycle hold-off; %0d mismatches.",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
